// ===== hw/rtl/grid_search_force_allocation_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Grid search force allocation: assertion macros
// Implication checks clocked on clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GRID_SEARCH_FORCE_ALLOCATION_UNIT_DEFINES_SVH
`define GRID_SEARCH_FORCE_ALLOCATION_UNIT_DEFINES_SVH

// same-cycle implication
`define GSFA_ASSERT_IMP(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define GSFA_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== hw/rtl/gsfa_pkg.sv =====
// ----------------------------------------------------------------------------
// gsfa_pkg
// Types and constants of the grid search force allocation unit.
// ----------------------------------------------------------------------------
package gsfa_pkg;

    localparam int VAL_W    = 16;
    localparam int ACC_W    = 50;
    localparam int DIST_W   = 50;
    localparam int NUM_AXES = 6;
    localparam int FRAC_W   = 12;
    localparam int IN_W     = 136;
    localparam int OUT_W    = 72;
    localparam int IDX_W    = 3;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;
    localparam logic signed [ACC_W:0] ACC_POS = 51'sd281474976710656;
    localparam logic signed [ACC_W:0] ACC_NEG = -51'sd281474976710656;

    localparam logic CFG_SOURCE_COUNT = 1'b0;
    localparam logic CFG_GRID_CUTS    = 1'b1;

    typedef enum logic [1:0] {
        MODE_LOAD_SRC = 2'd0,
        MODE_LOAD_TGT = 2'd1,
        MODE_RUN      = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_RD,
        ST_MUL,
        ST_ACC,
        ST_DSQ,
        ST_DADD,
        ST_CMP,
        ST_OUT
    } state_t;

endpackage

// ===== hw/rtl/gsfa_ram.sv =====
// ----------------------------------------------------------------------------
// gsfa_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gsfa_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 8
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/gsfa_div.sv =====
// ----------------------------------------------------------------------------
// gsfa_div
// Restoring divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module gsfa_div #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo,
    output logic [DEN_W-1:0] rem
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   trial;
    logic             bit_q;

    always_comb
    begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        bit_q = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= bit_q ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
            quo_reg <= {quo_reg[NUM_W-2:0], bit_q};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

// ===== hw/rtl/grid_search_force_allocation_unit.sv =====
// ----------------------------------------------------------------------------
// grid_search_force_allocation_unit
// Exhaustive grid search of source drives against a force/torque target.
// ----------------------------------------------------------------------------
// Usage:
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 sets
//   the source count, index 1 the grid cuts; always ready, write only while idle.
//   Input stream s_axis: tuser is the mode. Source and target loads produce
//   nothing. A run request starts the search; s_axis stays not ready until
//   all results of the run are taken.
//   Run, n sources and c cuts: a range division per source, then c^n grid
//   points, each with one source row read from the vector RAM, one multiply
//   row and one accumulate per source, then a squared distance step and an
//   add step per axis, and one compare.
//   Output stream m_axis: n results, one per source, tlast on the last.
//   Results are held while m_axis_tready is low; nothing is dropped.
//   Reset: sources, ranges and target clear to zero, count 1, cuts 2;
//   the vector RAM is masked by per-source valid bits, no clearing pass.
// ----------------------------------------------------------------------------
`include "grid_search_force_allocation_unit_defines.svh"

module grid_search_force_allocation_unit #(
    parameter int MAX_SOURCES = 8,
    parameter int MAX_CUTS    = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [4:0]                    cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // source_index, force_x, force_y, force_z, torque_x, torque_y, torque_z,
    // range_min, range_max, zero pad
    input  logic [gsfa_pkg::IN_W-1:0]     s_axis_tdata,
    // mode
    input  logic [1:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // drive_index, best_drive, best_distance_sq, zero pad
    output logic [gsfa_pkg::OUT_W-1:0]    m_axis_tdata,
    output logic                          m_axis_tlast
);

    import gsfa_pkg::*;

    localparam int SW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
    localparam int JW = $clog2(MAX_SOURCES + 1);
    localparam int CW = $clog2(MAX_CUTS + 1);
    localparam int QW = VAL_W + 2;
    localparam int RW = NUM_AXES * VAL_W;

    state_t state_reg, state_next;

    logic [3:0]    count_reg;
    logic [4:0]    cuts_reg;
    logic [JW-1:0] n_eff, n_reg;
    logic [CW-1:0] c_eff, c_reg;

    logic [MAX_SOURCES-1:0] vld_reg;
    logic signed [VAL_W-1:0] min_reg    [MAX_SOURCES];
    logic signed [VAL_W-1:0] max_reg    [MAX_SOURCES];
    logic signed [VAL_W-1:0] target_reg [NUM_AXES];
    logic signed [VAL_W-1:0] bestdrv_reg[MAX_SOURCES];
    logic [DIST_W-1:0]       best_reg;
    logic                    first_reg;

    logic [JW-1:0] j_reg;
    logic [JW-1:0] oj_reg;
    logic [2:0]    q_reg;

    logic signed [QW-1:0]    eq_reg  [MAX_SOURCES];
    logic [CW-1:0]           er_reg  [MAX_SOURCES];
    logic signed [VAL_W-1:0] drv_reg [MAX_SOURCES];
    logic [CW-1:0]           rem_reg [MAX_SOURCES];
    logic [CW-1:0]           dig_reg [MAX_SOURCES];

    logic signed [2*VAL_W-1:0] prod_reg [NUM_AXES];
    logic signed [ACC_W-1:0]   acc_reg  [NUM_AXES];
    logic [DIST_W-1:0]         dist_reg;
    logic [49:0]               hh_reg;
    logic [36:0]               hl_reg;
    logic [23:0]               ll_reg;
    logic                      big_reg;

    logic             in_acc, out_acc, cfg_acc;
    logic [2:0]       in_idx;
    logic             in_idx_ok;
    logic [SW-1:0]    jx, ojx;

    logic             div_start, div_done;
    logic [VAL_W-1:0] div_num, div_quo;
    logic [CW-1:0]    div_rem;
    logic signed [VAL_W:0] ext;
    logic             ext_neg_reg;

    logic [RW-1:0]    ram_rdata;

    logic [MAX_SOURCES-1:0] stp, wrp;
    logic                   fin;

    logic signed [ACC_W:0] dval;
    logic [ACC_W:0]        aval;
    logic [ACC_W:0]        frac;
    logic [ACC_W:0]        term;
    logic [DIST_W-1:0]     term_c;
    logic [DIST_W:0]       dsum;

    // ---------------- handshakes ----------------
    assign cfg_ready     = 1'b1;
    assign cfg_acc       = cfg_valid && cfg_ready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_acc       = m_axis_tvalid && m_axis_tready;
    assign in_idx        = s_axis_tdata[2:0];
    assign in_idx_ok     = (32'(in_idx) < MAX_SOURCES);
    assign jx            = j_reg[SW-1:0];
    assign ojx           = oj_reg[SW-1:0];

    always_comb
    begin
        if (count_reg == 4'd0)
        begin
            n_eff = JW'(1);
        end
        else if (32'(count_reg) > MAX_SOURCES)
        begin
            n_eff = JW'(MAX_SOURCES);
        end
        else
        begin
            n_eff = JW'(count_reg);
        end
        if (cuts_reg == 5'd0)
        begin
            c_eff = CW'(1);
        end
        else if (32'(cuts_reg) > MAX_CUTS)
        begin
            c_eff = CW'(MAX_CUTS);
        end
        else
        begin
            c_eff = CW'(cuts_reg);
        end
    end

    // ---------------- source vector RAM ----------------
    gsfa_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_SOURCES)
    ) u_vec_ram (
        .clk   (clk),
        .we    (in_acc && s_axis_tuser == MODE_LOAD_SRC && in_idx_ok),
        .waddr (SW'(in_idx)),
        .wdata (s_axis_tdata[RW+2:3]),
        .re    (state_reg == ST_RD),
        .raddr (jx),
        .rdata (ram_rdata)
    );

    // ---------------- range divider ----------------
    assign ext       = VAL_W'(max_reg[jx]) - VAL_W'(min_reg[jx]) == '0 ? '0 :
                       (VAL_W+1)'(max_reg[jx]) - (VAL_W+1)'(min_reg[jx]);
    assign div_num   = ext[VAL_W] ? VAL_W'(-ext) : VAL_W'(ext);
    assign div_start = (state_reg == ST_DIV_START);

    gsfa_div #(
        .NUM_W (VAL_W),
        .DEN_W (CW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (c_reg),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    // ---------------- grid point odometer ----------------
    always_comb
    begin
        logic carry;
        carry = 1'b1;
        fin   = 1'b0;
        for (int k = 0; k < MAX_SOURCES; k++)
        begin
            stp[k] = carry && (JW'(k) < n_reg);
            wrp[k] = stp[k] && (({1'b0, dig_reg[k]} + 1'b1) == {1'b0, c_reg});
            carry  = wrp[k];
            if (JW'(k + 1) == n_reg)
            begin
                fin = wrp[k];
            end
        end
    end

    // ---------------- distance term ----------------
    always_comb
    begin
        dval   = (ACC_W+1)'(acc_reg[q_reg])
                 - ((ACC_W+1)'(target_reg[q_reg]) <<< FRAC_W);
        aval   = dval[ACC_W] ? (ACC_W+1)'(-dval) : (ACC_W+1)'(dval);
        frac   = ((ACC_W+1)'({hl_reg, 13'b0}) + (ACC_W+1)'(ll_reg)) >> 24;
        term   = (ACC_W+1)'(hh_reg) + frac;
        term_c = (big_reg || term > (ACC_W+1)'(DIST_MAX)) ? DIST_MAX
                                                         : DIST_W'(term);
        dsum   = (DIST_W+1)'(dist_reg) + (DIST_W+1)'(term_c);
    end

    // ---------------- state machine ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && s_axis_tuser == MODE_RUN)
                begin
                    state_next = ST_DIV_START;
                end
            end
            ST_DIV_START:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = (j_reg + 1'b1 == n_reg) ? ST_RD : ST_DIV_START;
                end
            end
            ST_RD:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                state_next = (j_reg + 1'b1 == n_reg) ? ST_DSQ : ST_RD;
            end
            ST_DSQ:
            begin
                state_next = ST_DADD;
            end
            ST_DADD:
            begin
                state_next = (q_reg == 3'(NUM_AXES - 1)) ? ST_CMP : ST_DSQ;
            end
            ST_CMP:
            begin
                state_next = fin ? ST_OUT : ST_RD;
            end
            ST_OUT:
            begin
                if (out_acc && m_axis_tlast)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------- control and stored state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 4'd1;
            cuts_reg  <= 5'd2;
            vld_reg   <= '0;
            n_reg     <= JW'(1);
            c_reg     <= CW'(1);
            j_reg     <= '0;
            oj_reg    <= '0;
            q_reg     <= '0;
            first_reg <= 1'b0;
            best_reg  <= DIST_MAX;
            for (int k = 0; k < MAX_SOURCES; k++)
            begin
                min_reg[k]     <= '0;
                max_reg[k]     <= '0;
                bestdrv_reg[k] <= '0;
            end
            for (int k = 0; k < NUM_AXES; k++)
            begin
                target_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_acc)
            begin
                if (cfg_index == CFG_SOURCE_COUNT)
                begin
                    count_reg <= cfg_data[3:0];
                end
                else
                begin
                    cuts_reg <= cfg_data;
                end
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (s_axis_tuser == MODE_LOAD_SRC && in_idx_ok)
                        begin
                            vld_reg[SW'(in_idx)] <= 1'b1;
                            min_reg[SW'(in_idx)] <= s_axis_tdata[114:99];
                            max_reg[SW'(in_idx)] <= s_axis_tdata[130:115];
                        end
                        else if (s_axis_tuser == MODE_LOAD_TGT)
                        begin
                            for (int k = 0; k < NUM_AXES; k++)
                            begin
                                target_reg[k] <= s_axis_tdata[3 + k*VAL_W +: VAL_W];
                            end
                        end
                        else if (s_axis_tuser == MODE_RUN)
                        begin
                            n_reg     <= n_eff;
                            c_reg     <= c_eff;
                            j_reg     <= '0;
                            first_reg <= 1'b1;
                        end
                    end
                end
                ST_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        j_reg <= (j_reg + 1'b1 == n_reg) ? '0 : j_reg + 1'b1;
                    end
                end
                ST_ACC:
                begin
                    j_reg <= (j_reg + 1'b1 == n_reg) ? '0 : j_reg + 1'b1;
                    q_reg <= '0;
                end
                ST_DADD:
                begin
                    q_reg <= q_reg + 1'b1;
                end
                ST_CMP:
                begin
                    first_reg <= 1'b0;
                    j_reg     <= '0;
                    oj_reg    <= '0;
                    if (first_reg || dist_reg < best_reg)
                    begin
                        best_reg <= dist_reg;
                        for (int k = 0; k < MAX_SOURCES; k++)
                        begin
                            if (JW'(k) < n_reg)
                            begin
                                bestdrv_reg[k] <= drv_reg[k];
                            end
                        end
                    end
                end
                ST_OUT:
                begin
                    if (out_acc)
                    begin
                        oj_reg <= oj_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && s_axis_tuser == MODE_RUN)
                begin
                    for (int k = 0; k < MAX_SOURCES; k++)
                    begin
                        drv_reg[k] <= min_reg[k];
                        rem_reg[k] <= '0;
                        dig_reg[k] <= '0;
                    end
                    for (int k = 0; k < NUM_AXES; k++)
                    begin
                        acc_reg[k] <= '0;
                    end
                end
            end
            ST_DIV_START:
            begin
                ext_neg_reg <= ext[VAL_W];
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (!ext_neg_reg)
                    begin
                        eq_reg[jx] <= QW'({2'b00, div_quo});
                        er_reg[jx] <= div_rem;
                    end
                    else if (div_rem == '0)
                    begin
                        eq_reg[jx] <= -QW'({2'b00, div_quo});
                        er_reg[jx] <= '0;
                    end
                    else
                    begin
                        eq_reg[jx] <= -QW'({2'b00, div_quo}) - QW'(1);
                        er_reg[jx] <= c_reg - div_rem;
                    end
                end
            end
            ST_MUL:
            begin
                for (int k = 0; k < NUM_AXES; k++)
                begin
                    prod_reg[k] <= vld_reg[jx]
                        ? drv_reg[jx] * $signed(ram_rdata[k*VAL_W +: VAL_W])
                        : (2*VAL_W)'(0);
                end
            end
            ST_ACC:
            begin
                for (int k = 0; k < NUM_AXES; k++)
                begin
                    logic signed [ACC_W:0] s;
                    s = (ACC_W+1)'(acc_reg[k]) + (ACC_W+1)'(prod_reg[k]);
                    if (s > ACC_POS)
                    begin
                        acc_reg[k] <= ACC_W'(ACC_POS);
                    end
                    else if (s < ACC_NEG)
                    begin
                        acc_reg[k] <= ACC_W'(ACC_NEG);
                    end
                    else
                    begin
                        acc_reg[k] <= ACC_W'(s);
                    end
                end
                dist_reg <= '0;
            end
            ST_DSQ:
            begin
                big_reg <= (aval[ACC_W:37] != '0);
                hh_reg  <= aval[36:12] * aval[36:12];
                hl_reg  <= aval[36:12] * aval[11:0];
                ll_reg  <= aval[11:0] * aval[11:0];
            end
            ST_DADD:
            begin
                dist_reg <= (dsum > (DIST_W+1)'(DIST_MAX)) ? DIST_MAX : DIST_W'(dsum);
            end
            ST_CMP:
            begin
                for (int k = 0; k < NUM_AXES; k++)
                begin
                    acc_reg[k] <= '0;
                end
                for (int k = 0; k < MAX_SOURCES; k++)
                begin
                    logic [CW:0] sr;
                    sr = {1'b0, rem_reg[k]} + {1'b0, er_reg[k]};
                    if (wrp[k])
                    begin
                        dig_reg[k] <= '0;
                        drv_reg[k] <= min_reg[k];
                        rem_reg[k] <= '0;
                    end
                    else if (stp[k])
                    begin
                        dig_reg[k] <= dig_reg[k] + 1'b1;
                        if (sr >= {1'b0, c_reg})
                        begin
                            rem_reg[k] <= CW'(sr - {1'b0, c_reg});
                            drv_reg[k] <= VAL_W'(QW'(drv_reg[k]) + eq_reg[k] + QW'(1));
                        end
                        else
                        begin
                            rem_reg[k] <= CW'(sr);
                            drv_reg[k] <= VAL_W'(QW'(drv_reg[k]) + eq_reg[k]);
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // ---------------- result stream ----------------
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tlast  = (oj_reg + 1'b1 == n_reg);
    assign m_axis_tdata  = {3'b000, best_reg, bestdrv_reg[ojx], IDX_W'(oj_reg)};

    `GSFA_ASSERT_IMP(a_out_blocks_in, m_axis_tvalid, !s_axis_tready,
        "result pending while input ready")
    `GSFA_ASSERT_NEXT(a_last_ends_run, out_acc && m_axis_tlast, state_reg == ST_IDLE,
        "run did not end after last result")
    `GSFA_ASSERT_NEXT(a_run_starts, in_acc && s_axis_tuser == MODE_RUN,
        state_reg == ST_DIV_START, "run request did not start division")
    `GSFA_ASSERT_NEXT(a_point_restart, state_reg == ST_CMP,
        (state_reg == ST_RD || state_reg == ST_OUT) && j_reg == '0,
        "grid point step lost its source index")

endmodule
